@@ design/sfr_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfr_pkg;

    localparam int BYTE_W = 8;
    localparam int CNT_W  = 5;
    localparam int CFG_W  = 64;
    localparam int IDX_W  = 3;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [CNT_W-1:0]  cnt_t;

    // register indexes on the configuration port
    localparam logic [IDX_W-1:0] CFG_PATTERN_LOW    = 3'd0;
    localparam logic [IDX_W-1:0] CFG_PATTERN_HIGH   = 3'd1;
    localparam logic [IDX_W-1:0] CFG_PATTERN_LENGTH = 3'd2;
    localparam logic [IDX_W-1:0] CFG_REPLACE_LOW    = 3'd3;
    localparam logic [IDX_W-1:0] CFG_REPLACE_HIGH   = 3'd4;
    localparam logic [IDX_W-1:0] CFG_REPLACE_LENGTH = 3'd5;

    // input command codes
    localparam logic CMD_DATA  = 1'b0;
    localparam logic CMD_FLUSH = 1'b1;

    // where emitted bytes are taken from
    localparam logic SRC_PATTERN = 1'b0;
    localparam logic SRC_REPLACE = 1'b1;

endpackage

`default_nettype wire

@@ design/stream_find_replace.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Byte-stream find and replace. Every non-overlapping occurrence of the search
// pattern is replaced by the replacement bytes; bytes of a partial match are
// held back as a count and released from the pattern registers when the match
// breaks or when an end-of-stream flush arrives. An input transaction is taken
// only while the block is idle. On a mismatch a fallback search then tests one
// candidate length per cycle on a shared shifted-pattern comparator, from the
// match count down to one; the match count is at most MAX_PATTERN-1. The
// resulting bytes leave one per cycle through a single output register while
// the output side accepts them, up to MAX_PATTERN or MAX_REPLACE bytes; a new
// item is taken only once the last of them is in that register. Configuration
// must be written through the write port only while idle, not enforced by the
// block; writing the pattern length drops any partial match without output.
module stream_find_replace #(
    parameter int MAX_PATTERN = 16,
    parameter int MAX_REPLACE = 16
) (
    input  wire                           aclk,
    input  wire                           aresetn,

    input  wire                           cfg_wr_en,
    input  wire [sfr_pkg::IDX_W-1:0]      cfg_index,
    input  wire [sfr_pkg::CFG_W-1:0]      cfg_wdata,

    input  wire                           s_valid,
    output logic                          s_ready,
    input  wire                           s_cmd,
    input  wire [sfr_pkg::BYTE_W-1:0]     s_data_byte,

    output logic                          m_valid,
    input  wire                           m_ready,
    output logic [sfr_pkg::BYTE_W-1:0]    m_out_byte,
    output logic                          m_last_of_run,
    output logic                          m_flush_output
);

    localparam int PIW       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int REP_DEPTH = (MAX_REPLACE > 0) ? MAX_REPLACE : 1;
    localparam int RIW       = (REP_DEPTH > 1) ? $clog2(REP_DEPTH) : 1;
    localparam int LANES     = sfr_pkg::CFG_W / sfr_pkg::BYTE_W;

    localparam sfr_pkg::cnt_t MAXP = sfr_pkg::cnt_t'(MAX_PATTERN);
    localparam sfr_pkg::cnt_t MAXR = sfr_pkg::cnt_t'(MAX_REPLACE);
    localparam sfr_pkg::cnt_t ONE  = sfr_pkg::cnt_t'(1);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    // configuration storage
    sfr_pkg::byte_t pat_reg [MAX_PATTERN];
    sfr_pkg::byte_t rep_reg [REP_DEPTH];
    sfr_pkg::cnt_t  plen_raw_reg;
    sfr_pkg::cnt_t  rlen_raw_reg;

    for (genvar g = 0; g < MAX_PATTERN; g++) begin : g_pat
        localparam logic [sfr_pkg::IDX_W-1:0] SEL =
            (g < LANES) ? sfr_pkg::CFG_PATTERN_LOW : sfr_pkg::CFG_PATTERN_HIGH;
        localparam int LANE = g % LANES;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                pat_reg[g] <= '0;
            end else if (cfg_wr_en && cfg_index == SEL) begin
                pat_reg[g] <= cfg_wdata[LANE*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
            end
        end
    end

    for (genvar g = 0; g < REP_DEPTH; g++) begin : g_rep
        localparam logic [sfr_pkg::IDX_W-1:0] SEL =
            (g < LANES) ? sfr_pkg::CFG_REPLACE_LOW : sfr_pkg::CFG_REPLACE_HIGH;
        localparam int LANE = g % LANES;
        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                rep_reg[g] <= '0;
            end else if (cfg_wr_en && cfg_index == SEL) begin
                rep_reg[g] <= cfg_wdata[LANE*sfr_pkg::BYTE_W +: sfr_pkg::BYTE_W];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plen_raw_reg <= ONE;
            rlen_raw_reg <= '0;
        end else if (cfg_wr_en) begin
            if (cfg_index == sfr_pkg::CFG_PATTERN_LENGTH) begin
                plen_raw_reg <= cfg_wdata[sfr_pkg::CNT_W-1:0];
            end
            if (cfg_index == sfr_pkg::CFG_REPLACE_LENGTH) begin
                rlen_raw_reg <= cfg_wdata[sfr_pkg::CNT_W-1:0];
            end
        end
    end

    sfr_pkg::cnt_t plen;
    sfr_pkg::cnt_t rlen;

    always_comb begin
        if (plen_raw_reg == '0) begin
            plen = ONE;
        end else if (plen_raw_reg > MAXP) begin
            plen = MAXP;
        end else begin
            plen = plen_raw_reg;
        end
        rlen = (rlen_raw_reg > MAXR) ? MAXR : rlen_raw_reg;
    end

    // sequencer state
    logic [1:0]     state_reg,  state_next;
    sfr_pkg::cnt_t  match_reg,  match_next;
    sfr_pkg::cnt_t  try_reg,    try_next;
    sfr_pkg::byte_t byte_reg,   byte_next;
    logic           flush_reg,  flush_next;
    logic           src_reg,    src_next;
    sfr_pkg::cnt_t  cnt_reg,    cnt_next;
    logic           tail_reg,   tail_next;
    sfr_pkg::cnt_t  idx_reg,    idx_next;

    logic           m_valid_reg, m_valid_next;
    sfr_pkg::byte_t m_byte_reg,  m_byte_next;
    logic           m_last_reg,  m_last_next;
    logic           m_flush_reg, m_flush_next;

    // shared candidate check: does a fallback of length try_reg fit
    sfr_pkg::cnt_t          shift;
    sfr_pkg::cnt_t          try_m1;
    logic [MAX_PATTERN-1:0] lane_ok;
    logic                   cand_ok;

    always_comb begin
        sfr_pkg::cnt_t pos;
        shift   = match_reg - try_reg + ONE;
        try_m1  = try_reg - ONE;
        lane_ok = '1;
        for (int j = 0; j < MAX_PATTERN - 1; j++) begin
            pos = shift + sfr_pkg::cnt_t'(j);
            if (sfr_pkg::cnt_t'(j + 1) < try_reg) begin
                lane_ok[j] = (pos < MAXP) && (pat_reg[j] == pat_reg[pos[PIW-1:0]]);
            end
        end
        cand_ok = (pat_reg[try_m1[PIW-1:0]] == byte_reg) && (&lane_ok);
    end

    sfr_pkg::cnt_t  m_eff;
    sfr_pkg::cnt_t  total;
    sfr_pkg::byte_t emit_byte;
    logic           slot_free;

    assign m_eff     = (match_reg >= plen) ? '0 : match_reg;
    assign total     = cnt_reg + sfr_pkg::cnt_t'(tail_reg);
    assign slot_free = !m_valid_reg || m_ready;

    always_comb begin
        if (idx_reg < cnt_reg) begin
            if (src_reg == sfr_pkg::SRC_REPLACE) begin
                emit_byte = rep_reg[idx_reg[RIW-1:0]];
            end else begin
                emit_byte = pat_reg[idx_reg[PIW-1:0]];
            end
        end else begin
            emit_byte = byte_reg;
        end
    end

    always_comb begin
        state_next   = state_reg;
        match_next   = match_reg;
        try_next     = try_reg;
        byte_next    = byte_reg;
        flush_next   = flush_reg;
        src_next     = src_reg;
        cnt_next     = cnt_reg;
        tail_next    = tail_reg;
        idx_next     = idx_reg;
        m_valid_next = m_valid_reg;
        m_byte_next  = m_byte_reg;
        m_last_next  = m_last_reg;
        m_flush_next = m_flush_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    byte_next = s_data_byte;
                    idx_next  = '0;
                    src_next  = sfr_pkg::SRC_PATTERN;
                    tail_next = 1'b0;
                    flush_next = 1'b0;
                    match_next = m_eff;
                    if (s_cmd == sfr_pkg::CMD_FLUSH) begin
                        flush_next = 1'b1;
                        cnt_next   = m_eff;
                        match_next = '0;
                        if (m_eff != '0) begin
                            state_next = ST_EMIT;
                        end
                    end else if (s_data_byte == pat_reg[m_eff[PIW-1:0]]) begin
                        if (m_eff + ONE == plen) begin
                            match_next = '0;
                            src_next   = sfr_pkg::SRC_REPLACE;
                            cnt_next   = rlen;
                            if (rlen != '0) begin
                                state_next = ST_EMIT;
                            end
                        end else begin
                            match_next = m_eff + ONE;
                        end
                    end else if (m_eff == '0) begin
                        // lone byte, nothing held back
                        cnt_next   = '0;
                        tail_next  = 1'b1;
                        state_next = ST_EMIT;
                    end else begin
                        try_next   = m_eff;
                        state_next = ST_SEARCH;
                    end
                end
            end

            ST_SEARCH: begin
                if (cand_ok) begin
                    cnt_next   = match_reg + ONE - try_reg;
                    match_next = try_reg;
                    state_next = ST_EMIT;
                end else if (try_reg == ONE) begin
                    // no fallback: release the whole match and the new byte
                    cnt_next   = match_reg;
                    tail_next  = 1'b1;
                    match_next = '0;
                    state_next = ST_EMIT;
                end else begin
                    try_next = try_m1;
                end
            end

            ST_EMIT: begin
                if (slot_free) begin
                    m_valid_next = 1'b1;
                    m_byte_next  = emit_byte;
                    m_last_next  = (idx_reg + ONE == total);
                    m_flush_next = flush_reg;
                    idx_next     = idx_reg + ONE;
                    if (idx_reg + ONE == total) begin
                        state_next = ST_IDLE;
                    end
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_wr_en && cfg_index == sfr_pkg::CFG_PATTERN_LENGTH) begin
            match_next = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            match_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            match_reg   <= match_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        try_reg     <= try_next;
        byte_reg    <= byte_next;
        flush_reg   <= flush_next;
        src_reg     <= src_next;
        cnt_reg     <= cnt_next;
        tail_reg    <= tail_next;
        idx_reg     <= idx_next;
        m_byte_reg  <= m_byte_next;
        m_last_reg  <= m_last_next;
        m_flush_reg <= m_flush_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_out_byte     = m_byte_reg;
    assign m_last_of_run  = m_last_reg;
    assign m_flush_output = m_flush_reg;

endmodule

`default_nettype wire

@@ tb/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
    import sfr_pkg::*;

    localparam int HALF_PERIOD   = 6;
    localparam int CYCLE_LIMIT   = 1_500_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int RANDOM_ITEMS  = 420;
    localparam int PATTERN_MAX   = 16;
    localparam int REPLACE_MAX   = 16;
    localparam int NUM_ROWS      = 32;

    typedef struct packed {
        byte_t data;
        logic  last;
        logic  flush;
    } rewritten_byte_t;

    typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_e;

    typedef struct packed {
        row_kind_e        kind;
        logic [IDX_W-1:0] index;
        logic [CFG_W-1:0] value;
        logic             cmd;
        byte_t            data;
        logic             typed;
        logic [1:0]       n_typed;
        byte_t            typed_byte;
    } stim_row_t;

    logic             aclk;
    logic             aresetn;
    logic             cfg_wr_en;
    logic [IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0] cfg_wdata;
    logic             s_valid;
    logic             s_ready;
    logic             s_cmd;
    byte_t            s_data_byte;
    logic             m_valid;
    logic             m_ready;
    byte_t            m_out_byte;
    logic             m_last_of_run;
    logic             m_flush_output;

    // shadow copy of the block's registers and match state
    logic [CFG_W-1:0] pat_lo, pat_hi, rep_lo, rep_hi;
    cnt_t             pat_len, rep_len, matched;

    rewritten_byte_t  released_now[$];
    rewritten_byte_t  pending_out[$];

    int    mismatch_count = 0;
    int    cycle_count = 0;
    int    items_sent = 0;
    bit    tx_calm = 1'b0;
    byte_t alph_base = 8'h00;
    int    alph_span = 256;

    stim_row_t directed_rows [NUM_ROWS] = '{
        // reset state: pattern is a single zero byte, replacement empty
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h00, 1'b1, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'hFF, 1'b1, 2'd1, 8'hFF},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_FLUSH, 8'h00, 1'b1, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_FLUSH, 8'hAA, 1'b1, 2'd0, 8'h00},
        // self-overlapping pattern 01 02 01 02 03, saturated replace length
        '{ROW_CFG, CFG_PATTERN_LOW, 64'h0000_0003_0201_0201, CMD_DATA, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_CFG, CFG_PATTERN_HIGH, 64'hFFFF_FFFF_FFFF_FFFF, CMD_DATA, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_CFG, CFG_PATTERN_LENGTH, 64'd5, CMD_DATA, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_CFG, CFG_REPLACE_LOW, 64'hA7A6_A5A4_A3A2_A1A0, CMD_DATA, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_CFG, CFG_REPLACE_HIGH, 64'hAFAE_ADAC_ABAA_A9A8, CMD_DATA, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_CFG, CFG_REPLACE_LENGTH, 64'd31, CMD_DATA, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h01, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h02, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h01, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h02, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h01, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h02, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h03, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h01, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h02, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_FLUSH, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h01, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h05, 1'b0, 2'd0, 8'h00},
        // partial match dropped by a length write, zero length acts as one
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h01, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h02, 1'b0, 2'd0, 8'h00},
        '{ROW_CFG, CFG_PATTERN_LENGTH, 64'd0, CMD_DATA, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_FLUSH, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h01, 1'b0, 2'd0, 8'h00},
        '{ROW_CFG, CFG_REPLACE_LENGTH, 64'd0, CMD_DATA, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h01, 1'b0, 2'd0, 8'h00},
        // saturated pattern length, then pattern rewritten under a partial match
        '{ROW_CFG, CFG_PATTERN_LENGTH, 64'd31, CMD_DATA, 8'h00, 1'b0, 2'd0, 8'h00},
        '{ROW_ITEM, CFG_PATTERN_LOW, 64'd0, CMD_DATA, 8'h01, 1'b0, 2'd0, 8'h00},
        '{ROW_CFG, CFG_PATTERN_LOW, 64'hFFFF_FFFF_FFFF_FFFF, CMD_FLUSH, 8'h00, 1'b0, 2'd0, 8'h00}
    };

    stream_find_replace i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_cmd          (s_cmd),
        .s_data_byte    (s_data_byte),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_out_byte     (m_out_byte),
        .m_last_of_run  (m_last_of_run),
        .m_flush_output (m_flush_output)
    );

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    function automatic int eff_pattern_len();
        int n;
        n = pat_len;
        if (n == 0) n = 1;
        if (n > PATTERN_MAX) n = PATTERN_MAX;
        return n;
    endfunction

    function automatic int eff_replace_len();
        int n;
        n = rep_len;
        if (n > REPLACE_MAX) n = REPLACE_MAX;
        return n;
    endfunction

    function automatic byte_t pattern_byte(int i);
        logic [2*CFG_W-1:0] all;
        all = {pat_hi, pat_lo};
        return all[8*(i % 16) +: 8];
    endfunction

    function automatic byte_t replace_byte(int i);
        logic [2*CFG_W-1:0] all;
        all = {rep_hi, rep_lo};
        return all[8*(i % 16) +: 8];
    endfunction

    function automatic void apply_config(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        case (idx)
            CFG_PATTERN_LOW:    pat_lo = val;
            CFG_PATTERN_HIGH:   pat_hi = val;
            CFG_PATTERN_LENGTH: begin
                pat_len = val[CNT_W-1:0];
                matched = '0;
            end
            CFG_REPLACE_LOW:    rep_lo = val;
            CFG_REPLACE_HIGH:   rep_hi = val;
            CFG_REPLACE_LENGTH: rep_len = val[CNT_W-1:0];
            default: ;
        endcase
    endfunction

    function automatic void release_byte(byte_t b, logic fl);
        rewritten_byte_t r;
        r.data  = b;
        r.last  = 1'b0;
        r.flush = fl;
        released_now.push_back(r);
    endfunction

    // bytes of the rewritten stream that one input transaction releases
    function automatic void rewrite_input(logic cmd, byte_t b);
        int  plen, m, fb;
        bit  ok;
        released_now.delete();
        plen = eff_pattern_len();
        m = matched;
        if (m >= plen) m = 0;
        if (cmd == CMD_FLUSH) begin
            for (int i = 0; i < m; i++) release_byte(pattern_byte(i), 1'b1);
            matched = '0;
        end else if (b == pattern_byte(m)) begin
            m++;
            if (m == plen) begin
                for (int i = 0; i < eff_replace_len(); i++)
                    release_byte(replace_byte(i), 1'b0);
                m = 0;
            end
            matched = cnt_t'(m);
        end else begin
            // fall back to the longest pattern prefix that ends on this byte
            fb = 0;
            for (int t = m; t >= 1 && fb == 0; t--) begin
                if (pattern_byte(t - 1) == b) begin
                    ok = 1'b1;
                    for (int j = 0; j + 1 < t; j++)
                        if (pattern_byte(j) != pattern_byte(m - t + 1 + j)) ok = 1'b0;
                    if (ok) fb = t;
                end
            end
            if (fb > 0) begin
                for (int i = 0; i < m + 1 - fb; i++) release_byte(pattern_byte(i), 1'b0);
            end else begin
                for (int i = 0; i < m; i++) release_byte(pattern_byte(i), 1'b0);
                release_byte(b, 1'b0);
            end
            matched = cnt_t'(fb);
        end
        if (released_now.size() > 0) released_now[released_now.size() - 1].last = 1'b1;
    endfunction

    function automatic int pick_gap();
        int r;
        if (tx_calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic int pick_len(int hi_small);
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return 16;
        if (r < 17) return 0;
        if (r < 22) return $urandom_range(17, 31);
        return $urandom_range(1, hi_small);
    endfunction

    function automatic byte_t noise_byte();
        return alph_base + byte_t'($urandom_range(0, alph_span - 1));
    endfunction

    task automatic send_item(input logic cmd, input byte_t data, input bit typed,
                             input int n_typed, input byte_t typed_byte);
        int gap;
        rewritten_byte_t r;
        gap = pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_cmd       <= cmd;
        s_data_byte <= data;
        s_valid     <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        rewrite_input(cmd, data);
        if (typed) begin
            for (int i = 0; i < n_typed; i++) begin
                r.data  = typed_byte;
                r.last  = 1'b1;
                r.flush = 1'b0;
                pending_out.push_back(r);
            end
        end else begin
            foreach (released_now[i]) pending_out.push_back(released_now[i]);
        end
        items_sent++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (pending_out.size() != 0) @(posedge aclk);
    endtask

    // only called once the block is idle
    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        apply_config(idx, val);
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic quiesce();
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic configure_random(input bit first);
        logic [2*CFG_W-1:0] pbytes;
        int r;
        quiesce();
        r = $urandom_range(0, 99);
        alph_span = (r < 25) ? 256 : $urandom_range(1, 3);
        alph_base = byte_t'($urandom);
        for (int k = 0; k < 16; k++)
            pbytes[8*k +: 8] = noise_byte();
        if (first || $urandom_range(0, 4) != 0) write_reg(CFG_PATTERN_LOW, pbytes[CFG_W-1:0]);
        if (first || $urandom_range(0, 4) != 0) write_reg(CFG_PATTERN_HIGH, pbytes[2*CFG_W-1:CFG_W]);
        // leaving the length alone carries a partial match into the next burst
        if (first || $urandom_range(0, 3) != 0)
            write_reg(CFG_PATTERN_LENGTH, first ? 64'd16 : CFG_W'(pick_len(6)));
        if (first || $urandom_range(0, 4) != 0) write_reg(CFG_REPLACE_LOW, {$urandom, $urandom});
        if (first || $urandom_range(0, 4) != 0) write_reg(CFG_REPLACE_HIGH, {$urandom, $urandom});
        if (first || $urandom_range(0, 4) != 0)
            write_reg(CFG_REPLACE_LENGTH, first ? 64'd16 : CFG_W'(pick_len(8)));
    endtask

    task automatic run_burst(input int n);
        int start, r, plen, k;
        start = items_sent;
        while (items_sent - start < n) begin
            r = $urandom_range(0, 99);
            plen = eff_pattern_len();
            if ($urandom_range(0, 99) < 3) wait_drained();
            if (r < 55) begin
                k = ($urandom_range(0, 9) < 6) ? plen : $urandom_range(1, plen);
                for (int i = 0; i < k; i++) send_item(CMD_DATA, pattern_byte(i), 1'b0, 0, 8'h00);
                if ($urandom_range(0, 9) < 3) send_item(CMD_DATA, noise_byte(), 1'b0, 0, 8'h00);
            end else if (r < 80) begin
                send_item(CMD_DATA, noise_byte(), 1'b0, 0, 8'h00);
            end else if (r < 90) begin
                send_item(CMD_DATA, byte_t'($urandom), 1'b0, 0, 8'h00);
            end else begin
                send_item(CMD_FLUSH, byte_t'($urandom), 1'b0, 0, 8'h00);
            end
        end
    endtask

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    always @(posedge aclk) begin
        rewritten_byte_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_out.size() == 0) begin
                mismatch_count++;
                $display("%0t: unexpected output byte %h, nothing pending", $time, m_out_byte);
            end else begin
                want = pending_out.pop_front();
                if (m_out_byte !== want.data) begin
                    mismatch_count++;
                    $display("%0t: out_byte expected %h got %h", $time, want.data, m_out_byte);
                end
                if (m_last_of_run !== want.last) begin
                    mismatch_count++;
                    $display("%0t: last_of_run expected %b got %b",
                             $time, want.last, m_last_of_run);
                end
                if (m_flush_output !== want.flush) begin
                    mismatch_count++;
                    $display("%0t: flush_output expected %b got %b",
                             $time, want.flush, m_flush_output);
                end
            end
        end
    end

    // result side: random back-pressure with quiet stretches
    initial begin
        int hold, calm_left, r;
        bit calm;
        hold = 0;
        calm_left = 0;
        calm = 1'b0;
        m_ready = 1'b0;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (calm_left == 0) begin
                calm = ($urandom_range(0, 3) == 0);
                calm_left = $urandom_range(50, 300);
            end else begin
                calm_left--;
            end
            if (hold > 0) begin
                m_ready <= 1'b0;
                hold--;
            end else begin
                r = $urandom_range(0, 99);
                if (calm || r < 70) begin
                    m_ready <= 1'b1;
                end else if (r < 95) begin
                    m_ready <= 1'b0;
                    hold = $urandom_range(0, 3);
                end else begin
                    m_ready <= 1'b0;
                    hold = $urandom_range(10, 30);
                end
            end
        end
    end

    initial begin
        int directed_count;
        bit first;
        aresetn     = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_index   = CFG_PATTERN_LOW;
        cfg_wdata   = '0;
        s_valid     = 1'b0;
        s_cmd       = CMD_DATA;
        s_data_byte = 8'h00;
        pat_lo  = '0;
        pat_hi  = '0;
        rep_lo  = '0;
        rep_hi  = '0;
        pat_len = cnt_t'(1);
        rep_len = '0;
        matched = '0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (directed_rows[k]) begin
            if (directed_rows[k].kind == ROW_CFG) begin
                quiesce();
                write_reg(directed_rows[k].index, directed_rows[k].value);
                // the last row also closes with a flush of the rewritten pattern
                if (k == NUM_ROWS - 1)
                    send_item(CMD_FLUSH, 8'h00, 1'b0, 0, 8'h00);
            end else begin
                send_item(directed_rows[k].cmd, directed_rows[k].data, directed_rows[k].typed,
                          directed_rows[k].n_typed, directed_rows[k].typed_byte);
            end
        end

        directed_count = items_sent;
        first = 1'b1;
        while (items_sent < directed_count + RANDOM_ITEMS) begin
            configure_random(first);
            first = 1'b0;
            tx_calm = ($urandom_range(0, 3) == 0);
            run_burst($urandom_range(15, 45));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
